@@ hw/rtl/graph_m_coloring_check_defines.svh @@
// Assertion macros shared by the graph coloring checker RTL.
`ifndef GRAPH_M_COLORING_CHECK_DEFINES_SVH
`define GRAPH_M_COLORING_CHECK_DEFINES_SVH

`ifndef SYNTH

// Check a property on every rising edge of clk outside reset.
`define GMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define GMC_ASSERT_NEVER(lbl, cond, msg) \
	`GMC_ASSERT(lbl, !(cond), msg)

`else

`define GMC_ASSERT(lbl, prop, msg)
`define GMC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ hw/rtl/gmc_pkg.sv @@
// Shared types and constants of the graph coloring checker.
package gmc_pkg;

	localparam int V_W = 5;              // vertex number field
	localparam int C_W = 5;              // color code
	localparam int K_W = 6;              // search position, 0 .. num_vertices + 1
	localparam int NUM_CODES = 1 << C_W; // forbidden-color mask width

	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_NUM_VERTICES = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLORS   = 1'b1;

	// Edge write into the adjacency matrix.
	typedef struct packed {
		logic           wr;
		logic [V_W-1:0] a;
		logic [V_W-1:0] b;
	} gmc_edge_t;

	// Status of the search sequencer toward the top level.
	typedef struct packed {
		logic idle;
		logic done;
		logic colorable;
		logic clear;
	} gmc_stat_t;

endpackage

@@ hw/rtl/gmc_edge_if.sv @@
// Edge request channel.
interface gmc_edge_if import gmc_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [V_W-1:0] first_vertex;
	logic [V_W-1:0] second_vertex;
	logic           last_edge;

	modport source (output valid, first_vertex, second_vertex, last_edge, input ready);
	modport sink   (input valid, first_vertex, second_vertex, last_edge, output ready);
endinterface

@@ hw/rtl/gmc_result_if.sv @@
// Result request channel.
interface gmc_result_if ();
	logic valid;
	logic ready;
	logic colorable;

	modport source (output valid, colorable, input ready);
	modport sink   (input valid, colorable, output ready);
endinterface

@@ hw/rtl/gmc_cfg_if.sv @@
// Configuration write channel.
interface gmc_cfg_if import gmc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [C_W-1:0]        data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

@@ hw/rtl/gmc_adj.sv @@
// Adjacency bit matrix: edge writes, single-bit lookup, whole-matrix clear.
module gmc_adj import gmc_pkg::*; #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gmc_edge_t                         edge_wr,
	input  logic                              clear,
	input  logic [$clog2(MAX_VERTICES)-1:0]   row,
	input  logic [$clog2(MAX_VERTICES)-1:0]   col,
	output logic                              bit_out
);
	localparam int VW = $clog2(MAX_VERTICES);

	logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] adj_q;
	logic                                      ok;
	logic [VW-1:0]                             ra;
	logic [VW-1:0]                             rb;

	// drop self-loops and endpoints outside 1..MAX_VERTICES
	assign ok = edge_wr.wr && (edge_wr.a != '0) && (edge_wr.b != '0)
		&& (32'(edge_wr.a) <= MAX_VERTICES) && (32'(edge_wr.b) <= MAX_VERTICES)
		&& (edge_wr.a != edge_wr.b);
	assign ra = VW'(edge_wr.a - V_W'(1));
	assign rb = VW'(edge_wr.b - V_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_q <= '0;
		end else if (clear) begin
			adj_q <= '0;
		end else if (ok) begin
			adj_q[ra][rb] <= 1'b1;
			adj_q[rb][ra] <= 1'b1;
		end
	end

	assign bit_out = adj_q[row][col];
endmodule

@@ hw/rtl/gmc_search.sv @@
// Backtracking search sequencer with the vertex color store.
`include "graph_m_coloring_check_defines.svh"
module gmc_search import gmc_pkg::*; #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [V_W-1:0]                  n_vert,
	input  logic [C_W-1:0]                  n_col,
	input  logic                            res_take,
	input  logic                            adj_bit,
	output logic [$clog2(MAX_VERTICES)-1:0] adj_row,
	output logic [$clog2(MAX_VERTICES)-1:0] adj_col,
	output gmc_stat_t                       stat
);
	localparam int VW = $clog2(MAX_VERTICES);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_SCAN, S_DRAIN, S_SETUP, S_PICK, S_DONE
	} state_t;

	state_t                  state_q;
	logic [K_W-1:0]          k_q;
	logic [VW-1:0]           j_q;
	logic [VW-1:0]           j_s1;
	logic                    issue_s1;
	logic                    colv_s1;
	logic [C_W-1:0]          col_rd_s1;
	logic [C_W-1:0]          used_q;
	logic [C_W-1:0]          cur_q;
	logic [NUM_CODES-1:0]    forbid_q;
	logic [K_W-1:0]          c_q;
	logic [K_W-1:0]          limit_q;
	logic                    colorable_q;
	logic [MAX_VERTICES-1:0] color_vld_q;
	logic [C_W-1:0]          color_mem [MAX_VERTICES];

	logic [VW-1:0]           idx;
	logic [C_W-1:0]          col_s1;
	logic                    pick_fail;
	logic                    pick_hit;
	logic                    col_we;
	logic [C_W-1:0]          col_wd;
	logic [K_W-1:0]          used_inc;

	assign idx       = VW'(k_q - K_W'(1));
	assign col_s1    = colv_s1 ? col_rd_s1 : '0;
	assign pick_fail = (state_q == S_PICK) && (c_q > limit_q);
	assign pick_hit  = (state_q == S_PICK) && !pick_fail && !forbid_q[c_q[C_W-1:0]];
	assign col_we    = pick_fail || pick_hit;
	assign col_wd    = pick_hit ? c_q[C_W-1:0] : '0;
	assign used_inc  = K_W'(used_q) + K_W'(1);

	assign adj_row = idx;
	assign adj_col = j_s1;

	// color store: one write port, one registered read port
	always_ff @(posedge clk) begin
		col_rd_s1 <= color_mem[j_q];
		if (col_we) begin
			color_mem[idx] <= col_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= K_W'(1);
			j_q         <= '0;
			j_s1        <= '0;
			issue_s1    <= 1'b0;
			colv_s1     <= 1'b0;
			used_q      <= '0;
			cur_q       <= '0;
			forbid_q    <= '0;
			c_q         <= '0;
			limit_q     <= '0;
			colorable_q <= 1'b0;
			color_vld_q <= '0;
		end else begin
			issue_s1 <= (state_q == S_SCAN);
			j_s1     <= j_q;
			colv_s1  <= color_vld_q[j_q];

			// fold the color read last cycle into max-used, current color and forbidden mask
			if (issue_s1) begin
				if (j_s1 < idx && col_s1 > used_q) begin
					used_q <= col_s1;
				end
				if (j_s1 == idx) begin
					cur_q <= col_s1;
				end else if (adj_bit) begin
					forbid_q[col_s1] <= 1'b1;
				end
			end

			if (col_we) begin
				color_vld_q[idx] <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						k_q     <= K_W'(1);
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (k_q == '0 || k_q > K_W'(n_vert)) begin
						colorable_q <= (k_q != '0);
						state_q     <= S_DONE;
					end else begin
						j_q      <= '0;
						used_q   <= '0;
						cur_q    <= '0;
						forbid_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					j_q <= VW'(j_q + VW'(1));
					if ((32'(j_q) + 32'd1) == 32'(n_vert)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					c_q     <= K_W'(cur_q) + K_W'(1);
					limit_q <= (used_inc > K_W'(n_col)) ? K_W'(n_col) : used_inc;
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (pick_fail) begin
						k_q     <= k_q - K_W'(1);
						state_q <= S_CHECK;
					end else if (pick_hit) begin
						k_q     <= k_q + K_W'(1);
						state_q <= S_CHECK;
					end else begin
						c_q <= c_q + K_W'(1);
					end
				end
				S_DONE: begin
					if (res_take) begin
						color_vld_q <= '0;
						k_q         <= K_W'(1);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		stat.idle      = (state_q == S_IDLE);
		stat.done      = (state_q == S_DONE);
		stat.colorable = colorable_q;
		stat.clear     = (state_q == S_DONE) && res_take;
	end

	`GMC_ASSERT(a_start_idle, start |-> (state_q == S_IDLE), "search started while busy")
	`GMC_ASSERT(a_vertex_range, (state_q == S_SCAN || state_q == S_PICK) |-> (k_q != '0 && k_q <= K_W'(n_vert)), "search vertex out of range")
	`GMC_ASSERT(a_pick_color, pick_hit |-> (c_q != '0 && c_q <= K_W'(n_col)), "color above limit chosen")
	`GMC_ASSERT_NEVER(a_done_result, (state_q == S_DONE) && (colorable_q != (k_q != '0)), "result disagrees with search end")
endmodule

@@ hw/rtl/graph_m_coloring_check.sv @@
// Top level of the graph coloring checker: config, edge load, result register.
//
//   channel  dir  handshake      payload
//   edges    in   valid/ready    first_vertex[5], second_vertex[5], last_edge
//   result   out  valid/ready    colorable
//   cfg      in   valid/ready    addr[1], data[5]
//
// An edge is taken on each valid/ready handshake. After the last edge the search
// visits vertices on one color store: a visit checks, scans every vertex (one color
// read per vertex), drains, sets up and tries colors in turn, stepping back when none
// fits; a last check ends it. edges.ready is low from the last edge until its result
// enters the output register. Reset clears the matrix, colors and config (both
// registers to 1). The output register holds a result while result.ready is low.
module graph_m_coloring_check import gmc_pkg::*; #(
	parameter int MAX_VERTICES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	gmc_edge_if.sink     edges,
	gmc_result_if.source result,
	gmc_cfg_if.sink      cfg
);
	localparam int VW = $clog2(MAX_VERTICES);

	logic [V_W-1:0] nv_q;
	logic [C_W-1:0] nc_q;
	logic [V_W-1:0] n_sat;
	logic           out_valid_q;
	logic           out_col_q;
	logic           load;
	logic           start;
	logic           adj_bit;
	logic [VW-1:0]  adj_row;
	logic [VW-1:0]  adj_col;
	gmc_edge_t      edge_wr;
	gmc_stat_t      stat;

	assign cfg.ready   = 1'b1;
	assign edges.ready = stat.idle;

	assign edge_wr.wr = edges.valid && edges.ready;
	assign edge_wr.a  = edges.first_vertex;
	assign edge_wr.b  = edges.second_vertex;
	assign start      = edge_wr.wr && edges.last_edge;

	// saturate the vertex count to the matrix size
	assign n_sat = (32'(nv_q) > MAX_VERTICES) ? V_W'(MAX_VERTICES) : nv_q;

	assign load = stat.done && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= V_W'(1);
			nc_q <= C_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				REG_NUM_VERTICES: nv_q <= cfg.data;
				REG_NUM_COLORS:   nc_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_col_q <= stat.colorable;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.colorable = out_col_q;

	gmc_adj #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.edge_wr (edge_wr),
		.clear   (stat.clear),
		.row     (adj_row),
		.col     (adj_col),
		.bit_out (adj_bit)
	);

	gmc_search #(.MAX_VERTICES(MAX_VERTICES)) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.n_vert   (n_sat),
		.n_col    (nc_q),
		.res_take (load),
		.adj_bit  (adj_bit),
		.adj_row  (adj_row),
		.adj_col  (adj_col),
		.stat     (stat)
	);
endmodule
